### design/pdo_pkg.sv
package pdo_pkg;

   localparam int PHASE_BITS     = 32;
   localparam int SAMPLE_BITS    = 16;
   localparam int COS_TABLE_BITS = 10;

   // Q1.16 operands, 65536 is one
   localparam int FRAC_BITS = 16;
   localparam int Q16_W     = FRAC_BITS + 1;
   localparam logic [Q16_W-1:0] Q16_ONE = Q16_W'(1) << FRAC_BITS;

   localparam int STEP_W      = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL      = CSR_INDEX_W'(1);

   // quotient covers phase units up to one inclusive
   localparam int QUO_W      = PHASE_BITS + 1;
   localparam int PROD_W     = QUO_W + Q16_W;
   localparam int MUL_CNT_W  = $clog2(Q16_W + 1);
   localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

   localparam int TAB_N      = 1 << COS_TABLE_BITS;
   localparam int TAB_IDX_W  = COS_TABLE_BITS + 1;
   localparam int LUT_W      = COS_TABLE_BITS + 2;
   localparam int ENTRY_W    = SAMPLE_BITS;
   localparam logic [SAMPLE_BITS:0] SAMPLE_MAX = (SAMPLE_BITS + 1)'((1 << (SAMPLE_BITS - 1)) - 1);

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   typedef logic [ENTRY_W-1:0] cos_tab_type [0:TAB_N];

   // quarter-wave cosine, Q30 Taylor series with eight truncated terms
   function automatic cos_tab_type build_cos_tab();
      cos_tab_type     tab;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned c;
      longint unsigned r;
      longint          sum;
      for (int k = 0; k <= TAB_N; k++) begin
         x   = (PI_HALF_Q30 * 64'(k)) >> COS_TABLE_BITS;
         x2  = (x * x) >> 30;
         t   = 64'd1 << 30;
         sum = longint'(t);
         // term n is the previous one times x^2 over (2n-1)(2n)
         t   = ((t * x2) >> 30) / 64'd2;
         sum = sum - longint'(t);
         t   = ((t * x2) >> 30) / 64'd12;
         sum = sum + longint'(t);
         t   = ((t * x2) >> 30) / 64'd30;
         sum = sum - longint'(t);
         t   = ((t * x2) >> 30) / 64'd56;
         sum = sum + longint'(t);
         t   = ((t * x2) >> 30) / 64'd90;
         sum = sum - longint'(t);
         t   = ((t * x2) >> 30) / 64'd132;
         sum = sum + longint'(t);
         t   = ((t * x2) >> 30) / 64'd182;
         sum = sum - longint'(t);
         t   = ((t * x2) >> 30) / 64'd240;
         sum = sum + longint'(t);
         if (sum < 0) sum = 0;
         c = longint'(sum);
         r = (c + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
         tab[k] = ENTRY_W'(r);
      end
      return tab;
   endfunction

   localparam cos_tab_type COS_TAB = build_cos_tab();

   // 0.32 step rescaled to the accumulator width
   function automatic logic [PHASE_BITS-1:0] scale_step(input logic [STEP_W-1:0] s);
      logic [PHASE_BITS+STEP_W-1:0] w;
      w = (PHASE_BITS + STEP_W)'(s) << PHASE_BITS;
      return w[STEP_W +: PHASE_BITS];
   endfunction

endpackage

### design/pdo_mul.sv
module pdo_mul import pdo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [QUO_W-1:0]  multiplicand,
   input  logic [Q16_W-1:0]  multiplier,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   logic [QUO_W-1:0]     mcand_ff, mcand_in;
   logic [Q16_W-1:0]     mplier_ff, mplier_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   // shift-add, multiplier bits MSB first
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      done_in   = (cnt_ff == MUL_CNT_W'(1)) && !start;
      if (start) begin
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         acc_in    = '0;
         cnt_in    = MUL_CNT_W'(Q16_W);
      end else if (cnt_ff != '0) begin
         acc_in    = (acc_ff << 1) + (mplier_ff[Q16_W-1] ? PROD_W'(mcand_ff) : '0);
         mplier_in = mplier_ff << 1;
         cnt_in    = cnt_ff - MUL_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### design/pdo_div.sv
module pdo_div import pdo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [Q16_W-1:0]  divisor,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   logic [Q16_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [Q16_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [Q16_W:0]       trial;
   logic [Q16_W:0]       diff;
   logic                 ge;

   // restoring division; the quotient fits QUO_W bits, so the top of the
   // dividend is already below the divisor and seeds the remainder
   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = (cnt_ff == DIV_CNT_W'(1)) && !start;
      if (start) begin
         rem_in = dividend[PROD_W-1:QUO_W];
         quo_in = dividend[QUO_W-1:0];
         dvs_in = divisor;
         cnt_in = DIV_CNT_W'(QUO_W);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? diff[Q16_W-1:0] : trial[Q16_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/pdo_cos.sv
module pdo_cos import pdo_pkg::*; (
   input  logic                   clock,
   input  logic [LUT_W-1:0]       phase_hi,
   output logic [SAMPLE_BITS-1:0] sample
);

   logic [1:0]             quad;
   logic [TAB_IDX_W-1:0]   addr;
   logic [ENTRY_W-1:0]     entry_ff;
   logic                   neg_ff;
   logic [SAMPLE_BITS:0]   mag;
   logic [SAMPLE_BITS:0]   val;

   assign quad = phase_hi[LUT_W-1:LUT_W-2];
   // odd quadrants read the table mirrored
   assign addr = quad[0] ? TAB_IDX_W'(TAB_N) - {1'b0, phase_hi[COS_TABLE_BITS-1:0]}
                         : {1'b0, phase_hi[COS_TABLE_BITS-1:0]};

   always_ff @(posedge clock) begin
      entry_ff <= COS_TAB[addr];
      neg_ff   <= quad[1] ^ quad[0];
   end

   always_comb begin
      mag = {1'b0, entry_ff};
      if (neg_ff) val = -mag;
      else if (mag > SAMPLE_MAX) val = SAMPLE_MAX;
      else val = mag;
   end

   assign sample = val[SAMPLE_BITS-1:0];

endmodule

### design/phase_distortion_oscillator_unit.sv
// A request passes through a 17-step serial multiply, a 33-step serial divide,
//   one registered table read and the output load before rsp_valid rises.
// A new request is accepted only after the last result is loaded; a finished
//   result waits in ST_LOOK while the output register is still held by rsp_stall.
// Reset (synchronous, active high) clears the phase accumulator, both CSRs and
//   all control state.
module phase_distortion_oscillator_unit import pdo_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [Q16_W-1:0]              req_breakpoint,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_write_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_LOOK = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [Q16_W-1:0]       level_ff, level_in;
   logic                   lower_ff, lower_in;
   logic [Q16_W-1:0]       den_ff, den_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;

   logic                   accept;
   logic [Q16_W-1:0]       brk;
   logic [Q16_W-1:0]       lvl;
   logic [QUO_W-1:0]       brk_phase;
   logic [QUO_W-1:0]       p_ext;
   logic                   lower;
   logic [QUO_W-1:0]       mul_a;
   logic [Q16_W-1:0]       mul_b;
   logic                   mul_done;
   logic [PROD_W-1:0]      mul_product;
   logic                   div_done;
   logic [QUO_W-1:0]       div_quotient;
   logic [PHASE_BITS-1:0]  bent;
   logic [SAMPLE_BITS-1:0] cos_sample;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      brk       = (req_breakpoint > Q16_ONE) ? Q16_ONE : req_breakpoint;
      lvl       = (level_ff > Q16_ONE) ? Q16_ONE : level_ff;
      brk_phase = QUO_W'(brk) << (PHASE_BITS - FRAC_BITS);
      p_ext     = {1'b0, phase_ff};
      lower     = p_ext < brk_phase;
      // upper segment works on the distance to one
      mul_a     = lower ? p_ext : (QUO_W'(1) << PHASE_BITS) - p_ext;
      mul_b     = lower ? lvl : Q16_ONE - lvl;
   end

   pdo_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (accept),
      .multiplicand (mul_a),
      .multiplier   (mul_b),
      .done         (mul_done),
      .product      (mul_product)
   );

   pdo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_done),
      .dividend (mul_product),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // one minus the quotient wraps to the same phase modulo one
   assign bent = lower_ff ? div_quotient[PHASE_BITS-1:0] : -div_quotient[PHASE_BITS-1:0];

   pdo_cos u_cos (
      .clock    (clock),
      .phase_hi (bent[PHASE_BITS-1 -: LUT_W]),
      .sample   (cos_sample)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      level_in      = level_ff;
      lower_in      = lower_ff;
      den_in        = den_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_PHASE_STEP: step_in = csr_write_data[STEP_W-1:0];
            CSR_LEVEL:      level_in = csr_write_data[Q16_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lower_in = lower;
               den_in   = lower ? brk : Q16_ONE - brk;
               phase_in = phase_ff + scale_step(step_ff);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = cos_sample;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         step_ff      <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lower_ff      <= lower_in;
      den_ff        <= den_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

`ifndef SYNTHESIS
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL)
      else $error("multiply finished outside the multiply phase");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divide finished outside the divide phase");

   a_look_to_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished sample not moved to the output register");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_LOOK)
      else $error("response raised without a finished sample");
`endif

endmodule

### sim/tb_top.sv
module tb_top;
   import pdo_pkg::*;

   localparam int CLK_HALF        = 6;
   localparam int RESET_CYCLES    = 6;
   localparam int DRAIN_CYCLES    = 64;
   localparam int TIMEOUT_CYCLES  = 1000000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 88;
   localparam int MAX_REPORTS     = 10;
   localparam int QUARTER         = 1 << COS_TABLE_BITS;
   localparam int SAMPLE_TOP      = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned PHASE_ONE   = 64'd1 << PHASE_BITS;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = CSR_INDEX_W'(3);

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_type;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic [Q16_W-1:0]              req_breakpoint   = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index        = CSR_PHASE_STEP;
   logic [CSR_DATA_W-1:0]         csr_write_data   = '0;

   logic [Q16_W-1:0]              breakpoints_waiting[$];
   logic signed [SAMPLE_BITS-1:0] samples_due[$];
   int                            cos_quarter [0:QUARTER];

   // oscillator copy kept in step with the block
   logic [PHASE_BITS-1:0] osc_phase = '0;
   logic [STEP_W-1:0]     step_cfg  = '0;
   logic [Q16_W-1:0]      level_cfg = '0;

   int idle_pct        = 0;
   int stall_pct       = 0;
   int items_queued    = 0;
   int samples_checked = 0;
   int fault_count     = 0;

   always #(CLK_HALF) clock = ~clock;

   phase_distortion_oscillator_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_breakpoint   (req_breakpoint),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // quarter-wave cosine points, Q30 Taylor series with truncated terms
   initial begin
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      for (int k = 0; k <= QUARTER; k++) begin
         x    = (HALF_PI_Q30 * 64'(k)) >> COS_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         acc  = longint'(term);
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
         end
         if (acc < 0) acc = 0;
         cos_quarter[k] = int'((acc + (64'sd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS));
      end
   end

   // bends the current phase, looks up the cosine, then advances the phase
   function automatic logic signed [SAMPLE_BITS-1:0] step_oscillator(logic [Q16_W-1:0] bp);
      longint unsigned       b;
      longint unsigned       lv;
      longint unsigned       p;
      longint unsigned       bent;
      logic [PHASE_BITS-1:0] wrapped;
      logic [COS_TABLE_BITS-1:0] slot;
      int                    value;
      b  = 64'((bp > Q16_ONE) ? Q16_ONE : bp);
      lv = 64'((level_cfg > Q16_ONE) ? Q16_ONE : level_cfg);
      p  = 64'(osc_phase);
      if (p < (b << (PHASE_BITS - FRAC_BITS)))
         bent = (p * lv) / b;
      else
         bent = PHASE_ONE - ((PHASE_ONE - p) * (64'(Q16_ONE) - lv)) / (64'(Q16_ONE) - b);
      // a bent phase of exactly one wraps to zero
      wrapped = bent[PHASE_BITS-1:0];
      slot    = wrapped[PHASE_BITS-3 -: COS_TABLE_BITS];
      case (quadrant_type'(wrapped[PHASE_BITS-1 -: 2]))
         QUAD_I:   value = cos_quarter[slot];
         QUAD_II:  value = -cos_quarter[QUARTER - int'(slot)];
         QUAD_III: value = -cos_quarter[slot];
         default:  value = cos_quarter[QUARTER - int'(slot)];
      endcase
      if (value > SAMPLE_TOP) value = SAMPLE_TOP;
      osc_phase = osc_phase + step_cfg;
      return SAMPLE_BITS'(value);
   endfunction

   function automatic logic [Q16_W-1:0] random_breakpoint();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) return '0;
      else if (pick < 16) return Q16_ONE;
      else if (pick < 24) return Q16_W'($urandom_range(2 ** Q16_W - 1, 32'(Q16_ONE) + 1));
      else if (pick < 32) return Q16_W'($urandom_range(255));
      else if (pick < 40) return Q16_W'($urandom_range(32'(Q16_ONE), 32'(Q16_ONE) - 255));
      else return Q16_W'($urandom_range(32'(Q16_ONE)));
   endfunction

   task automatic flag_fault(string msg);
      if (fault_count < MAX_REPORTS) $display("%s", msg);
      fault_count++;
   endtask

   task automatic queue_breakpoint(logic [Q16_W-1:0] bp);
      breakpoints_waiting.push_back(bp);
      items_queued++;
   endtask

   task automatic wait_drained();
      while (samples_checked != items_queued) @(posedge clock);
   endtask

   // only called with nothing in flight; the mirror tracks what the block latches
   task automatic program_csrs(logic [CSR_DATA_W-1:0] step_word,
                               logic [CSR_DATA_W-1:0] level_word);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PHASE_STEP;
      csr_write_data   <= step_word;
      step_cfg = step_word[STEP_W-1:0];
      @(posedge clock);
      csr_index      <= CSR_LEVEL;
      csr_write_data <= level_word;
      level_cfg = level_word[Q16_W-1:0];
      // unused index, must not disturb either register
      @(posedge clock);
      csr_index      <= ($urandom_range(1) != 0) ? CSR_SPARE_A : CSR_SPARE_B;
      csr_write_data <= $urandom;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // request side: one transaction per accepted breakpoint
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) samples_due.push_back(step_oscillator(req_breakpoint));
         if (!req_valid || !req_stall) begin
            if (breakpoints_waiting.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid      <= 1'b1;
               req_breakpoint <= breakpoints_waiting.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side
   always @(posedge clock) begin
      logic signed [SAMPLE_BITS-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (samples_due.size() == 0) begin
               flag_fault($sformatf("unexpected sample_out %0d", rsp_sample_out));
            end else begin
               want = samples_due.pop_front();
               if (rsp_sample_out !== want)
                  flag_fault($sformatf("sample_out mismatch: expected %0d, got %0d",
                                       want, rsp_sample_out));
            end
            samples_checked++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      logic [Q16_W-1:0]      bends_mid_level[$] = '{'0, Q16_ONE, 17'd1, 17'd65535, 17'd32768,
                                                     17'd65537, 17'h1FFFF, 17'd16384, 17'd49152,
                                                     17'd100};
      logic [Q16_W-1:0]      bends_full_level[$] = '{'0, Q16_ONE, 17'd20000, 17'd40000,
                                                      17'h1FFFF, 17'd32768};
      logic [Q16_W-1:0]      bends_zero_level[$] = '{'0, Q16_ONE, 17'd30000, 17'd50000,
                                                      17'd1, 17'd65535};
      logic [CSR_DATA_W-1:0] step_word;
      logic [CSR_DATA_W-1:0] level_word;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      program_csrs(32'h0400_0000, 32'h0000_8000);
      foreach (bends_mid_level[i]) queue_breakpoint(bends_mid_level[i]);
      wait_drained();

      // upper bits dropped, remainder above one clamps to one
      program_csrs(32'h1000_0000, 32'hFFFF_FFFF);
      foreach (bends_full_level[i]) queue_breakpoint(bends_full_level[i]);
      wait_drained();

      program_csrs(32'h0C00_0001, '0);
      foreach (bends_zero_level[i]) queue_breakpoint(bends_zero_level[i]);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 48; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 30; stall_pct = 30; end
         endcase
         case (ph)
            0: begin step_word = '1;            level_word = 32'(Q16_ONE); end
            1: begin step_word = '0;            level_word = '0;           end
            2: begin step_word = 32'h8000_0000; level_word = 32'h0001_FFFF; end
            default: begin
               step_word  = ($urandom_range(1) != 0) ? $urandom : $urandom_range(32'h0100_0000);
               level_word = $urandom_range(32'(Q16_ONE));
            end
         endcase
         program_csrs(step_word, level_word);
         repeat (ITEMS_PER_PHASE) queue_breakpoint(random_breakpoint());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && samples_due.size() == 0) begin
         $display("phase_distortion_oscillator_unit verification clean");
      end else begin
         $display("phase_distortion_oscillator_unit verification failed");
      end
      $finish;
   end

   initial begin
      #(2 * CLK_HALF * TIMEOUT_CYCLES);
      $display("phase_distortion_oscillator_unit verification failed");
      $finish;
   end

endmodule

### filelist.f
design/pdo_pkg.sv
design/pdo_mul.sv
design/pdo_div.sv
design/pdo_cos.sv
design/phase_distortion_oscillator_unit.sv
sim/tb_top.sv
